### design/mie_pkg.sv
package mie_pkg;

  // Commands from the sequencer to the shared divider.
  typedef struct packed {
    logic start;    // latch the operands and begin a division
    logic coef_en;  // also update the Bezout coefficient
  } div_ctrl_t;

  // Status from the shared divider back to the sequencer.
  typedef struct packed {
    logic done;     // one-cycle pulse, results are valid from here on
  } div_stat_t;

endpackage

### design/modular_inverse_ext_euclid.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   value_in_i, modulus_i
// out      output     out_valid_o / out_ready_i inverse_o, has_inverse_o
//
// One item at a time. The value is reduced by the shared shift-subtract
// divider, then each Euclid step uses the same divider. in_ready_o is high
// only while the sequencer is idle. A result that is not taken holds the
// sequencer in its final state; reset clears all control state.
module modular_inverse_ext_euclid
  import mie_pkg::*;
#(
  parameter int WORD_BITS = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] value_in_i,
  input  logic [WORD_BITS-1:0] modulus_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_BITS-1:0] inverse_o,
  output logic                 has_inverse_o
);

  localparam int W = WORD_BITS;

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StLoad     = 3'd1;
  localparam logic [2:0] StWaitRed  = 3'd2;
  localparam logic [2:0] StStep     = 3'd3;
  localparam logic [2:0] StWaitStep = 3'd4;
  localparam logic [2:0] StFinish   = 3'd5;

  logic [2:0]          state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic [W-1:0]        val_q, val_d;
  logic [W-1:0]        mod_q, mod_d;
  logic [W-1:0]        r0_q, r0_d;
  logic [W-1:0]        r1_q, r1_d;
  logic signed [W+1:0] t0_q, t0_d;
  logic signed [W+1:0] t1_q, t1_d;
  logic [W-1:0]        inv_q, inv_d;
  logic                has_q, has_d;

  div_ctrl_t           div_ctrl;
  div_stat_t           div_stat;
  logic [W-1:0]        div_num;
  logic [W-1:0]        div_den;
  logic signed [W+1:0] div_base;
  logic [W-1:0]        div_rem;
  logic signed [W+1:0] div_coef;
  logic signed [W+1:0] t_norm;

  // Divider operands: the reduction step first, then the Euclid steps.
  always_comb begin
    if (state_q == StLoad) begin
      div_num  = val_q;
      div_den  = mod_q;
      div_base = '0;
    end else begin
      div_num  = r0_q;
      div_den  = r1_q;
      div_base = t0_q;
    end
  end

  assign div_ctrl.start   = (state_q == StLoad) ||
                            ((state_q == StStep) && (r1_q != '0));
  assign div_ctrl.coef_en = (state_q == StStep);

  mie_div #(
    .W (W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .num_i       (div_num),
    .den_i       (div_den),
    .coef_base_i (div_base),
    .coef_step_i (t1_q),
    .stat_o      (div_stat),
    .rem_o       (div_rem),
    .coef_o      (div_coef)
  );

  // A coefficient that is not positive is moved up by one modulus.
  assign t_norm = (t0_q <= 0) ? (t0_q + $signed({2'b00, mod_q})) : t0_q;

  // Sequencer over the reduction, the Euclid steps and the result.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    val_d       = val_q;
    mod_d       = mod_q;
    r0_d        = r0_q;
    r1_d        = r1_q;
    t0_d        = t0_q;
    t1_d        = t1_q;
    inv_d       = inv_q;
    has_d       = has_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          val_d = value_in_i;
          mod_d = modulus_i;
          r0_d  = '0;
          if (modulus_i < W'(2)) begin
            state_d = StFinish;
          end else begin
            state_d = StLoad;
          end
        end
      end
      StLoad: begin
        state_d = StWaitRed;
      end
      StWaitRed: begin
        if (div_stat.done) begin
          r0_d    = mod_q;
          r1_d    = div_rem;
          t0_d    = '0;
          t1_d    = (W+2)'(1);
          state_d = StStep;
        end
      end
      StStep: begin
        if (r1_q == '0) begin
          state_d = StFinish;
        end else begin
          state_d = StWaitStep;
        end
      end
      StWaitStep: begin
        if (div_stat.done) begin
          r0_d    = r1_q;
          r1_d    = div_rem;
          t0_d    = t1_q;
          t1_d    = div_coef;
          state_d = StStep;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (r0_q == W'(1)) begin
            inv_d = t_norm[W-1:0];
            has_d = 1'b1;
          end else begin
            inv_d = '0;
            has_d = 1'b0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and the output item.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    mod_q <= mod_d;
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    t0_q  <= t0_d;
    t1_q  <= t1_d;
    inv_q <= inv_d;
    has_q <= has_d;
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign inverse_o     = inv_q;
  assign has_inverse_o = has_q;

endmodule

### design/mie_div.sv
module mie_div
  import mie_pkg::*;
#(
  parameter int W = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_ctrl_t           ctrl_i,
  input  logic [W-1:0]        num_i,
  input  logic [W-1:0]        den_i,
  input  logic signed [W+1:0] coef_base_i,
  input  logic signed [W+1:0] coef_step_i,
  output div_stat_t           stat_o,
  output logic [W-1:0]        rem_o,
  output logic signed [W+1:0] coef_o
);

  localparam int CntW = (W > 1) ? $clog2(W) : 1;

  localparam logic [1:0] DivIdle = 2'd0;
  localparam logic [1:0] DivNorm = 2'd1;
  localparam logic [1:0] DivSub  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic                done_q, done_d;
  logic                coef_en_q, coef_en_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [W-1:0]        rem_q, rem_d;
  logic [W-1:0]        dvs_q, dvs_d;
  logic signed [W+1:0] stp_q, stp_d;
  logic signed [W+1:0] acc_q, acc_d;

  logic norm_go;
  logic sub_go;

  // The doubled divisor still fits under the remainder: keep normalizing.
  assign norm_go = ({dvs_q, 1'b0} <= {1'b0, rem_q});
  // The current shifted divisor can be taken from the remainder.
  assign sub_go  = (dvs_q <= rem_q);

  // Shift-subtract sequencer. The divisor is first shifted up to the top
  // quotient bit, then walked back down one bit per cycle. With coef_en, every
  // quotient bit that is set takes the equally shifted coefficient step off
  // the accumulator, so it ends at base - quotient * step; else it keeps base.
  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    coef_en_d = coef_en_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    stp_d     = stp_q;
    acc_d     = acc_q;
    case (state_q)
      DivIdle: begin
        if (ctrl_i.start) begin
          rem_d     = num_i;
          dvs_d     = den_i;
          stp_d     = coef_step_i;
          acc_d     = coef_base_i;
          coef_en_d = ctrl_i.coef_en;
          cnt_d     = '0;
          state_d   = DivNorm;
        end
      end
      DivNorm: begin
        if (norm_go) begin
          dvs_d = {dvs_q[W-2:0], 1'b0};
          stp_d = stp_q <<< 1;
          cnt_d = cnt_q + 1'b1;
        end else begin
          state_d = DivSub;
        end
      end
      DivSub: begin
        if (sub_go) begin
          rem_d = rem_q - dvs_q;
          if (coef_en_q) begin
            acc_d = acc_q - stp_q;
          end
        end
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = DivIdle;
        end else begin
          dvs_d = {1'b0, dvs_q[W-1:1]};
          stp_d = stp_q >>> 1;
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = DivIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= DivIdle;
      done_q    <= 1'b0;
      coef_en_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      coef_en_q <= coef_en_d;
      cnt_q     <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    stp_q <= stp_d;
    acc_q <= acc_d;
  end

  assign stat_o.done = done_q;
  assign rem_o       = rem_q;
  assign coef_o      = acc_q;

endmodule

### verif/modular_inverse_ext_euclid_tb.sv
`timescale 1ns / 1ps

module modular_inverse_ext_euclid_tb;

  localparam int W = 31;
  localparam logic [W-1:0] MAX_WORD = {W{1'b1}};
  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_TAIL = 40;
  localparam int SETTLE_CYCLES = 4000;

  // One input item waiting to be driven.
  typedef struct {
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    bit           drain;   // hold off until every result is back
    bit           bursty;  // idle bursts allowed around this item
  } pending_item_t;

  // One expected result item.
  typedef struct packed {
    logic [W-1:0] inverse;
    logic         has_inverse;
  } inv_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_ready_o;
  logic [W-1:0] value_in_i = '0;
  logic [W-1:0] modulus_i = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  logic [W-1:0] inverse_o;
  logic         has_inverse_o;

  pending_item_t pending_items[$];
  inv_result_t   inv_expected[$];
  logic          idle_bursts = 1'b0;
  int            send_gap = 0;
  int            recv_stall = 0;
  int            failures = 0;

  modular_inverse_ext_euclid #(
    .WORD_BITS(W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_in_i   (value_in_i),
    .modulus_i    (modulus_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inverse_o    (inverse_o),
    .has_inverse_o(has_inverse_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Extended Euclid on 64-bit integers, tracking the coefficient of the value.
  function automatic inv_result_t predict_inverse(input logic [W-1:0] value,
                                                  input logic [W-1:0] modulus);
    longint unsigned rem_prev, rem_cur, quot, rem_next;
    longint          coef_prev, coef_cur, coef_next;
    inv_result_t     res;
    res = '0;
    if (modulus < 2) return res;
    rem_prev  = modulus;
    rem_cur   = value % modulus;
    coef_prev = 0;
    coef_cur  = 1;
    while (rem_cur != 0) begin
      quot      = rem_prev / rem_cur;
      rem_next  = rem_prev - quot * rem_cur;
      rem_prev  = rem_cur;
      rem_cur   = rem_next;
      coef_next = coef_prev - longint'(quot) * coef_cur;
      coef_prev = coef_cur;
      coef_cur  = coef_next;
    end
    if (rem_prev != 1) return res;
    if (coef_prev <= 0) coef_prev += longint'(modulus);
    res.inverse     = coef_prev[W-1:0];
    res.has_inverse = 1'b1;
    return res;
  endfunction

  task automatic add_item(input logic [W-1:0] value, input logic [W-1:0] modulus);
    pending_item_t item;
    int            idx;
    idx          = pending_items.size();
    item.value   = value;
    item.modulus = modulus;
    item.drain   = (idx == 150) || (idx == 300);
    item.bursty  = ((idx / 50) % 2) == 0;
    pending_items.push_back(item);
  endtask

  // Input driver: records each accepted item and launches the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_in_i <= '0;
      modulus_i  <= '0;
      send_gap   <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        inv_expected.push_back(predict_inverse(value_in_i, modulus_i));
      end
      if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   (!pending_items[0].drain || inv_expected.size() == 0)) begin
        if (pending_items[0].bursty && $urandom_range(0, 3) == 0) begin
          send_gap   <= $urandom_range(0, 15);
          in_valid_i <= 1'b0;
        end else begin
          value_in_i  <= pending_items[0].value;
          modulus_i   <= pending_items[0].modulus;
          idle_bursts <= pending_items[0].bursty;
          in_valid_i  <= 1'b1;
          void'(pending_items.pop_front());
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor: compares each result item and stalls the output at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (inv_expected.size() == 0) begin
          $error("unexpected result item: inverse=%0d has_inverse=%0b",
                 inverse_o, has_inverse_o);
          failures++;
        end else begin
          if (inverse_o !== inv_expected[0].inverse) begin
            $error("inverse: expected %0d, actual %0d",
                   inv_expected[0].inverse, inverse_o);
            failures++;
          end
          if (has_inverse_o !== inv_expected[0].has_inverse) begin
            $error("has_inverse: expected %0b, actual %0b",
                   inv_expected[0].has_inverse, has_inverse_o);
            failures++;
          end
          void'(inv_expected.pop_front());
        end
      end
      if (recv_stall > 0) begin
        recv_stall  <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
        recv_stall  <= $urandom_range(0, 15);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    longint unsigned fib[0:46];
    logic [W-1:0]    modulus, factor;
    int              kind, idx;
    fib[0] = 0;
    fib[1] = 1;
    for (int k = 2; k <= 46; k++) fib[k] = fib[k-1] + fib[k-2];

    // Directed: extremes, no-inverse cases, moduli below two, worst-case Euclid.
    add_item(W'(0), W'(2));
    add_item(W'(1), W'(2));
    add_item(W'(0), W'(7));
    add_item(W'(7), W'(7));
    add_item(W'(14), W'(7));
    add_item(W'(6), W'(9));
    add_item(W'(3), W'(10));
    add_item(W'(1), MAX_WORD);
    add_item(MAX_WORD, MAX_WORD);
    add_item(W'(MAX_WORD - 1), MAX_WORD);
    add_item(MAX_WORD, W'(MAX_WORD - 1));
    add_item(W'(2), 31'h4000_0000);
    add_item(31'h2AAA_AAAB, 31'h5555_5555);
    add_item(W'(fib[45]), W'(fib[46]));
    add_item(W'(fib[46]), W'(fib[45]));
    add_item(W'(5), W'(0));
    add_item(W'(5), W'(1));
    add_item(W'(0), W'(0));
    add_item(MAX_WORD, W'(0));
    add_item(MAX_WORD, W'(1));
    add_item(MAX_WORD, W'(3));

    // Random mix of item shapes.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          add_item(W'($urandom() & MAX_WORD), W'($urandom_range(2, MAX_WORD)));
        end
        4: begin
          add_item(W'($urandom() & MAX_WORD), W'($urandom_range(0, 64)));
        end
        5: begin
          modulus = W'($urandom_range(2, 46340));
          add_item(W'(modulus * $urandom_range(0, 46340)), modulus);
        end
        6: begin
          factor = W'($urandom_range(2, 1000));
          add_item(W'(factor * $urandom_range(0, 2000000)),
                   W'(factor * $urandom_range(1, 2000000)));
        end
        7: begin
          idx = $urandom_range(2, 45);
          add_item(W'(fib[idx]), W'(fib[idx+1]));
        end
        8: begin
          modulus = W'($urandom_range(2, MAX_WORD));
          add_item(W'(modulus - 1), modulus);
        end
        default: begin
          add_item(W'($urandom() & MAX_WORD), MAX_WORD);
        end
      endcase
    end

    // The tail of the run goes without idling.
    for (int k = pending_items.size() - CALM_TAIL; k < pending_items.size(); k++) begin
      pending_items[k].bursty = 1'b0;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (inv_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
design/mie_pkg.sv
design/mie_div.sv
design/modular_inverse_ext_euclid.sv
verif/modular_inverse_ext_euclid_tb.sv
